@@ sv/rbs_pkg.sv @@
// rbs_pkg: shared types, register map and reset values for the raw10 unpack
// and bayer split block. No dependencies.
package rbs_pkg;

  localparam int MAX_ROW_BYTES_DEF = 8192;
  localparam int MAX_ROWS_DEF      = 8192;

  // plane width and height saturate here
  localparam int PLANE_MAX = 4096;

  localparam int QUEUE_DEPTH = 2;

  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_ROW_BYTES  = 2'd0;
  localparam logic [1:0] REG_FRAME_ROWS = 2'd1;
  localparam logic [1:0] REG_OUT_WIDTH  = 2'd2;
  localparam logic [1:0] REG_OUT_HEIGHT = 2'd3;

  localparam logic [13:0] ROW_BYTES_RST  = 14'd4128;
  localparam logic [13:0] FRAME_ROWS_RST = 14'd2480;
  localparam logic [12:0] OUT_WIDTH_RST  = 13'd1640;
  localparam logic [12:0] OUT_HEIGHT_RST = 13'd1232;

  typedef struct packed {
    logic [13:0] row_bytes;
    logic [13:0] frame_rows;
    logic [12:0] out_width;
    logic [12:0] out_height;
  } cfg_t;

  // one complete 5-byte group, cropped pixels already masked off
  typedef struct packed {
    logic [3:0][9:0] pix;
    logic [3:0]      keep;
    logic [11:0]     x_base;
    logic [11:0]     plane_y;
    logic            row_odd;
  } grp_t;

endpackage

@@ sv/rbs_front.sv @@
// rbs_front: byte intake, row/column/group counting and group assembly.
// Depends on rbs_pkg.
module rbs_front #(
  parameter int MAX_ROW_BYTES = rbs_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_ROWS      = rbs_pkg::MAX_ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  rbs_pkg::cfg_t cfg,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] raw_byte
  input  logic          s_tuser,   // [0] frame_start
  input  logic          q_full,
  output logic          q_push,
  output rbs_pkg::grp_t q_data
);

  localparam int CW = $clog2(MAX_ROW_BYTES + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);

  logic [CW-1:0] column_count, column_count_next;
  logic [CW-1:0] grp_index, grp_index_next;
  logic [CW+2:0] grp_end, grp_end_next;     // 5 * (grp_index + 1)
  logic [2:0]    col_mod5, col_mod5_next;
  logic [2:0]    group_phase, group_phase_next;
  logic [RW-1:0] row_count, row_count_next;
  logic [7:0]    byte_hold [4];

  logic          fire;
  logic [CW-1:0] rb_eff;
  logic [RW-1:0] fr_eff;
  logic [12:0]   w_eff, h_eff;
  logic [CW-1:0] col_eff, grp_eff;
  logic [CW+2:0] end_eff;
  logic [2:0]    mod_eff, phase_eff;
  logic [RW-1:0] row_eff;
  logic          in_full;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic [CW:0]   px [4];
  logic [RW-2:0] py;

  assign s_tready = !q_full;
  assign fire     = s_tvalid && s_tready;

  always_comb begin
    if (32'(cfg.row_bytes) > 32'(MAX_ROW_BYTES)) rb_eff = CW'(MAX_ROW_BYTES);
    else rb_eff = CW'(cfg.row_bytes);
    if (cfg.frame_rows == 14'd0) fr_eff = RW'(1);
    else if (32'(cfg.frame_rows) > 32'(MAX_ROWS)) fr_eff = RW'(MAX_ROWS);
    else fr_eff = RW'(cfg.frame_rows);
    w_eff = (32'(cfg.out_width) > rbs_pkg::PLANE_MAX) ? 13'(rbs_pkg::PLANE_MAX)
                                                       : cfg.out_width;
    h_eff = (32'(cfg.out_height) > rbs_pkg::PLANE_MAX) ? 13'(rbs_pkg::PLANE_MAX)
                                                        : cfg.out_height;
  end

  // frame start clears the counters before the byte is counted
  always_comb begin
    col_eff   = s_tuser ? '0 : column_count;
    grp_eff   = s_tuser ? '0 : grp_index;
    end_eff   = s_tuser ? (CW+3)'(5) : grp_end;
    mod_eff   = s_tuser ? 3'd0 : col_mod5;
    phase_eff = s_tuser ? 3'd0 : group_phase;
    row_eff   = s_tuser ? '0 : row_count;
    in_full   = end_eff <= (CW+3)'(rb_eff);
    col_inc   = (CW+1)'(col_eff) + (CW+1)'(1);
    row_inc   = (RW+1)'(row_eff) + (RW+1)'(1);

    column_count_next = CW'(col_inc);
    grp_index_next    = grp_eff;
    grp_end_next      = end_eff;
    col_mod5_next     = mod_eff + 3'd1;
    row_count_next    = row_eff;
    group_phase_next  = phase_eff;

    if (in_full) begin
      group_phase_next = (phase_eff < 3'd4) ? phase_eff + 3'd1 : 3'd0;
    end
    if (mod_eff == 3'd4) begin
      col_mod5_next  = 3'd0;
      grp_index_next = grp_eff + CW'(1);
      grp_end_next   = end_eff + (CW+3)'(5);
    end
    if (col_inc >= (CW+1)'(rb_eff)) begin
      column_count_next = '0;
      grp_index_next    = '0;
      grp_end_next      = (CW+3)'(5);
      col_mod5_next     = 3'd0;
      group_phase_next  = 3'd0;
      row_count_next    = (row_inc >= (RW+1)'(fr_eff)) ? '0 : RW'(row_inc);
    end
  end

  // four pixels of the group, crop applied per pixel
  always_comb begin
    py = row_eff[RW-1:1];
    for (int p = 0; p < 4; p++) begin
      px[p] = {grp_eff, 1'b0} + (CW+1)'(p / 2);
      q_data.pix[p]  = {byte_hold[p], s_tdata[7-2*p -: 2]};
      q_data.keep[p] = (32'(px[p]) < 32'(w_eff)) && (32'(py) < 32'(h_eff));
    end
    q_data.x_base  = 12'({grp_eff, 1'b0});
    q_data.plane_y = 12'(h_eff - 13'd1 - 13'(py));
    q_data.row_odd = row_eff[0];
    q_push = fire && in_full && (phase_eff == 3'd4) && (q_data.keep != 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      grp_index    <= '0;
      grp_end      <= (CW+3)'(5);
      col_mod5     <= 3'd0;
      group_phase  <= 3'd0;
      row_count    <= '0;
    end else if (fire) begin
      column_count <= column_count_next;
      grp_index    <= grp_index_next;
      grp_end      <= grp_end_next;
      col_mod5     <= col_mod5_next;
      group_phase  <= group_phase_next;
      row_count    <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_full && (phase_eff < 3'd4)) begin
      byte_hold[phase_eff[1:0]] <= s_tdata;
    end
  end

  assert property (@(posedge clk) disable iff (rst) group_phase <= 3'd4)
    else $error("group phase out of range");
  assert property (@(posedge clk) disable iff (rst)
    grp_end == (CW+3)'(grp_index) * (CW+3)'(5) + (CW+3)'(5))
    else $error("group end out of step with group index");

endmodule

@@ sv/rbs_queue.sv @@
// rbs_queue: short register queue of assembled groups between front and back.
// Depends on rbs_pkg.
module rbs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rbs_pkg::grp_t push_data,
  input  logic          pop,
  output rbs_pkg::grp_t pop_data,
  output logic          full,
  output logic          empty
);

  localparam int DEPTH = rbs_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  rbs_pkg::grp_t slot [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] fill;

  assign full     = fill == NW'(DEPTH);
  assign empty    = fill == '0;
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) fill <= fill + NW'(1);
      else if (pop && !push) fill <= fill - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue underflow");

endmodule

@@ sv/rbs_back.sv @@
// rbs_back: walks the kept pixels of each group, one per cycle unless m_tready stalls,
// into the output register. Depends on rbs_pkg.
module rbs_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  rbs_pkg::grp_t q_data,
  output logic          q_pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [39:0]   m_tdata,  // [9:0] pixel_value, [21:10] plane_x, [33:22] plane_y
  output logic [1:0]    m_tuser,  // [1:0] bayer_channel
  output logic          m_tlast   // last_of_group
);

  rbs_pkg::grp_t cur;
  logic          cur_valid;
  logic [3:0]    cur_keep;
  logic [3:0]    keep_next;
  logic [1:0]    sel;
  logic          advance;

  assign advance = cur_valid && (!m_tvalid || m_tready);

  // lowest kept pixel goes next
  always_comb begin
    if (cur_keep[0]) sel = 2'd0;
    else if (cur_keep[1]) sel = 2'd1;
    else if (cur_keep[2]) sel = 2'd2;
    else sel = 2'd3;
    keep_next = cur_keep & ~(4'd1 << sel);
    q_pop = !q_empty && (!cur_valid || (advance && keep_next == 4'd0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (q_pop) cur_valid <= 1'b1;
      else if (advance && keep_next == 4'd0) cur_valid <= 1'b0;
      if (advance) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur      <= q_data;
      cur_keep <= q_data.keep;
    end else if (advance) begin
      cur_keep <= keep_next;
    end
    if (advance) begin
      m_tdata <= {6'd0, cur.plane_y, {cur.x_base[11:1], sel[1]}, cur.pix[sel]};
      m_tuser <= {cur.row_odd, sel[0]};
      m_tlast <= keep_next == 4'd0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cur_valid |-> cur_keep != 4'd0)
    else $error("active group with no pixels left");
  assert property (@(posedge clk) disable iff (rst)
    (advance && keep_next != 4'd0) |=> cur_valid)
    else $error("group dropped before its last pixel");

endmodule

@@ sv/raw10_unpack_bayer_split_core.sv @@
// raw10_unpack_bayer_split_core: top level, config registers and the
// front / queue / back chain. Depends on rbs_pkg, rbs_front, rbs_queue, rbs_back.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  raw_byte (tdata), frame_start (tuser)
//  m_*       out  m_tvalid/m_tready  pixel, plane_x, plane_y (tdata),
//                                    bayer_channel (tuser), last_of_group (tlast)
//  apb       in   psel/penable       register writes and reads, pready tied high
//
// one byte accepted per cycle while the queue has room; pixels leave at one per cycle
// unless m_tready stalls, so four pixels per five bytes backs up intake only on a stall.
// first pixel of a group goes via the queue slot, current-group and output registers.
// s_tready drops only when the two-entry group queue is full.
// reset is synchronous and clears counters, queue and output valid.
module raw10_unpack_bayer_split_core #(
  parameter int MAX_ROW_BYTES = rbs_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_ROWS      = rbs_pkg::MAX_ROWS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [7:0] raw_byte
  input  logic                      s_tuser,   // [0] frame_start
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [39:0]               m_tdata,   // [9:0] pixel_value, [21:10] plane_x,
                                               // [33:22] plane_y
  output logic [1:0]                m_tuser,   // [1:0] bayer_channel
  output logic                      m_tlast,   // last_of_group
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rbs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  rbs_pkg::cfg_t cfg;
  rbs_pkg::grp_t push_data, pop_data;
  logic          push, pop, q_full, q_empty;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_bytes  <= rbs_pkg::ROW_BYTES_RST;
      cfg.frame_rows <= rbs_pkg::FRAME_ROWS_RST;
      cfg.out_width  <= rbs_pkg::OUT_WIDTH_RST;
      cfg.out_height <= rbs_pkg::OUT_HEIGHT_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        rbs_pkg::REG_ROW_BYTES:  cfg.row_bytes  <= pwdata[13:0];
        rbs_pkg::REG_FRAME_ROWS: cfg.frame_rows <= pwdata[13:0];
        rbs_pkg::REG_OUT_WIDTH:  cfg.out_width  <= pwdata[12:0];
        rbs_pkg::REG_OUT_HEIGHT: cfg.out_height <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rbs_pkg::REG_ROW_BYTES:  prdata = 32'(cfg.row_bytes);
      rbs_pkg::REG_FRAME_ROWS: prdata = 32'(cfg.frame_rows);
      rbs_pkg::REG_OUT_WIDTH:  prdata = 32'(cfg.out_width);
      rbs_pkg::REG_OUT_HEIGHT: prdata = 32'(cfg.out_height);
      default:                 prdata = 32'd0;
    endcase
  end

  rbs_front #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES),
    .MAX_ROWS     (MAX_ROWS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_full  (q_full),
    .q_push  (push),
    .q_data  (push_data)
  );

  rbs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .full     (q_full),
    .empty    (q_empty)
  );

  rbs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (pop_data),
    .q_pop   (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule
